>>> rtl/ldsu_pkg.sv
// ldsu_pkg: shared types and constants of the linear Diophantine solver.
// No dependencies; imported by every module of the block.
package ldsu_pkg;

	// default operand width of the solver
	localparam int DATA_WIDTH_DEF = 32;

	// guard bits on the Bezout coefficient registers over DATA_WIDTH
	localparam int COEF_XTRA = 3;

	// result status codes
	typedef enum logic [1:0] {
		ST_SOLVED   = 2'd0,
		ST_NOSOL    = 2'd1,
		ST_INFINITE = 2'd2
	} status_t;

	// saturation limits of the 63-bit solution ports
	localparam logic signed [62:0] SOL_MAX = {1'b0, {62{1'b1}}};
	localparam logic signed [62:0] SOL_MIN = {1'b1, {62{1'b0}}};

endpackage

>>> rtl/ldsu_mul.sv
// ldsu_mul: registered coefficient times quotient multiply, then sign fix and clamp.
// Depends on ldsu_pkg (solution limits).
module ldsu_mul #(
	parameter int CW = ldsu_pkg::DATA_WIDTH_DEF + ldsu_pkg::COEF_XTRA
) (
	input  logic                 clk,
	input  logic signed [CW-1:0] coef,
	input  logic signed [CW-1:0] quo,
	input  logic                 neg,
	output logic signed [62:0]   res
);
	import ldsu_pkg::*;

	localparam int PW = 2 * CW;
	localparam int EW = (PW > 64) ? PW : 64;
	localparam logic signed [EW-1:0] MAX_E = EW'(SOL_MAX);
	localparam logic signed [EW-1:0] MIN_E = EW'(SOL_MIN);

	logic signed [PW-1:0] prod_s1;
	logic                 neg_s1;
	logic signed [EW-1:0] p_ext;
	logic signed [EW-1:0] fixed;

	// product register, one multiply per cycle
	always_ff @(posedge clk) begin
		prod_s1 <= coef * quo;
		neg_s1  <= neg;
	end

	// sign fix and saturation to the 63-bit field
	always_comb begin
		p_ext = EW'(prod_s1);
		fixed = neg_s1 ? -p_ext : p_ext;
		if (fixed > MAX_E) begin
			res = SOL_MAX;
		end else if (fixed < MIN_E) begin
			res = SOL_MIN;
		end else begin
			res = 63'(fixed);
		end
	end

endmodule

>>> rtl/linear_diophantine_solver_unit.sv
// linear_diophantine_solver_unit: one particular solution of a*x + b*y = c.
// Depends on ldsu_pkg and ldsu_mul.
//
//  channel | handshake            | fields
//  --------+----------------------+-----------------------------------------
//  in      | start & !busy        | coef_a, coef_b, rhs_c (low DATA_WIDTH bits)
//  out     | done (1-cycle pulse) | sol_x, sol_y, divisor, status
//
// Euclid runs on one shift/compare/subtract unit: each quotient shifts the
// divisor up until it passes the remainder, then takes one restoring step per
// bit on the way down. The division of |c| by the gcd reuses the same unit,
// then S_MULX and S_MULY drive the one multiplier and S_FIN finishes. With
// both coefficients zero the unit goes straight to S_FIN. busy is high from
// acceptance until the done pulse; done cannot be held off. Reset clears the
// sequencer only.
module linear_diophantine_solver_unit #(
	parameter int DATA_WIDTH = ldsu_pkg::DATA_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [31:0]      coef_a,
	input  logic signed [31:0]      coef_b,
	input  logic signed [31:0]      rhs_c,
	output logic                    done,
	output logic signed [62:0]      sol_x,
	output logic signed [62:0]      sol_y,
	output logic [30:0]             divisor,
	output ldsu_pkg::status_t       status
);
	import ldsu_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int RW = DW + 1;
	localparam int CW = DW + COEF_XTRA;
	localparam int KW = $clog2(DW + 1);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_LOOP = 7'b0000010,
		S_UP   = 7'b0000100,
		S_DOWN = 7'b0001000,
		S_MULX = 7'b0010000,
		S_MULY = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	state_t st_q;
	logic   mode_q;       // 0: Euclid, 1: dividing |c| by the gcd
	logic   done_q;
	logic   a_neg_q, b_neg_q, c_neg_q;
	logic [DW-1:0] cmag_q;
	logic [DW-1:0] rp_q, rc_q, g_q;
	logic [RW-1:0] rs_q;
	logic [KW-1:0] k_q;
	logic signed [CW-1:0] up_q, vp_q, uc_q, vc_q, us_q, vs_q, bu_q, bv_q;
	status_t stat_q;
	logic signed [62:0] x_q, y_q;

	logic [DW-1:0] a_raw, b_raw, c_raw, a_mag, b_mag, c_mag;
	logic [RW-1:0] rs_half;
	logic signed [CW-1:0] us_half, vs_half;
	logic take, up_fits, fin_now;
	logic [DW-1:0] rp_dn, fin_rem;
	logic signed [CW-1:0] up_dn, vp_dn, fin_u, fin_v;
	logic signed [CW-1:0] mul_coef;
	logic mul_neg;
	logic signed [62:0] mul_res;
	logic [31:0] g32;

	// operand magnitudes; the most negative value maps to 2^(DW-1)
	always_comb begin
		a_raw = coef_a[DW-1:0];
		b_raw = coef_b[DW-1:0];
		c_raw = rhs_c[DW-1:0];
		a_mag = a_raw[DW-1] ? (~a_raw + DW'(1)) : a_raw;
		b_mag = b_raw[DW-1] ? (~b_raw + DW'(1)) : b_raw;
		c_mag = c_raw[DW-1] ? (~c_raw + DW'(1)) : c_raw;
	end

	// shared shift / compare / subtract unit
	always_comb begin
		rs_half = rs_q >> 1;
		us_half = us_q >>> 1;
		vs_half = vs_q >>> 1;
		up_fits = (rs_q <= {1'b0, rp_q});
		take    = (rs_half <= {1'b0, rp_q});
		rp_dn   = take ? (rp_q - rs_half[DW-1:0]) : rp_q;
		up_dn   = take ? (up_q - us_half) : up_q;
		vp_dn   = take ? (vp_q - vs_half) : vp_q;
	end

	// end of one quotient: remainder and updated coefficients
	always_comb begin
		fin_now = ((st_q == S_UP) && !up_fits && (k_q == '0))
			|| ((st_q == S_DOWN) && (k_q == KW'(1)));
		fin_rem = (st_q == S_DOWN) ? rp_dn : rp_q;
		fin_u   = (st_q == S_DOWN) ? up_dn : up_q;
		fin_v   = (st_q == S_DOWN) ? vp_dn : vp_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (start) begin
						a_neg_q <= a_raw[DW-1];
						b_neg_q <= b_raw[DW-1];
						c_neg_q <= c_raw[DW-1];
						cmag_q  <= c_mag;
						mode_q  <= 1'b0;
						rp_q    <= b_mag;
						rc_q    <= a_mag;
						up_q    <= '0;
						vp_q    <= CW'(1);
						uc_q    <= CW'(1);
						vc_q    <= '0;
						x_q     <= '0;
						y_q     <= '0;
						g_q     <= '0;
						if (a_mag == '0 && b_mag == '0) begin
							stat_q <= (c_mag == '0) ? ST_INFINITE : ST_NOSOL;
							st_q   <= S_FIN;
						end else begin
							stat_q <= ST_SOLVED;
							st_q   <= S_LOOP;
						end
					end
				end
				S_LOOP: begin
					k_q  <= '0;
					st_q <= S_UP;
					if (rc_q == '0) begin
						// gcd found; divide |c| by it, quotient builds in up_q
						g_q    <= rp_q;
						bu_q   <= up_q;
						bv_q   <= vp_q;
						mode_q <= 1'b1;
						rp_q   <= cmag_q;
						rs_q   <= {1'b0, rp_q};
						us_q   <= '1;
						vs_q   <= '0;
						up_q   <= '0;
						vp_q   <= '0;
					end else begin
						rs_q <= {1'b0, rc_q};
						us_q <= uc_q;
						vs_q <= vc_q;
					end
				end
				S_UP: begin
					if (up_fits) begin
						rs_q <= rs_q << 1;
						us_q <= us_q <<< 1;
						vs_q <= vs_q <<< 1;
						k_q  <= k_q + KW'(1);
					end else if (k_q != '0) begin
						st_q <= S_DOWN;
					end
				end
				S_DOWN: begin
					rs_q <= rs_half;
					us_q <= us_half;
					vs_q <= vs_half;
					k_q  <= k_q - KW'(1);
					rp_q <= rp_dn;
					up_q <= up_dn;
					vp_q <= vp_dn;
				end
				S_MULX: begin
					st_q <= S_MULY;
				end
				S_MULY: begin
					x_q  <= mul_res;
					st_q <= S_FIN;
				end
				S_FIN: begin
					if (stat_q == ST_SOLVED) begin
						y_q <= mul_res;
					end
					done_q <= 1'b1;
					st_q   <= S_IDLE;
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase

			// quotient complete: rotate Euclid pair or leave the division
			if (fin_now) begin
				if (!mode_q) begin
					rp_q <= rc_q;
					rc_q <= fin_rem;
					up_q <= uc_q;
					uc_q <= fin_u;
					vp_q <= vc_q;
					vc_q <= fin_v;
					st_q <= S_LOOP;
				end else if (fin_rem != '0) begin
					stat_q <= ST_NOSOL;
					st_q   <= S_FIN;
				end else begin
					st_q <= S_MULX;
				end
			end
		end
	end

	// x first, then y, through the one multiplier
	assign mul_coef = (st_q == S_MULY) ? bv_q : bu_q;
	assign mul_neg  = (st_q == S_MULY) ? (b_neg_q ^ c_neg_q) : (a_neg_q ^ c_neg_q);

	ldsu_mul #(
		.CW(CW)
	) u_mul (
		.clk  (clk),
		.coef (mul_coef),
		.quo  (up_q),
		.neg  (mul_neg),
		.res  (mul_res)
	);

	// outputs; gcd of 2^31 saturates in the 31-bit field
	assign g32     = 32'(g_q);
	assign divisor = g32[31] ? '1 : g32[30:0];
	assign busy    = (st_q != S_IDLE);
	assign done    = done_q;
	assign sol_x   = x_q;
	assign sol_y   = y_q;
	assign status  = stat_q;

endmodule

>>> rtl/ldsu_checker.sv
// ldsu_checker: port-level assertions for the solver unit, bound to its top level.
// Depends on ldsu_pkg (status codes) and linear_diophantine_solver_unit.
module ldsu_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic signed [62:0]  sol_x,
	input logic signed [62:0]  sol_y,
	input logic [30:0]         divisor,
	input ldsu_pkg::status_t   status
);
	import ldsu_pkg::*;

	// an accepted item keeps the unit busy on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// a result closes a busy period and frees the unit in the same cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
		else $error("done without a preceding busy period");

	// one result per item: no back-to-back pulses
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// solutions are zero unless solved
	a_zero_unsolved: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_SOLVED) |-> (sol_x == '0) && (sol_y == '0))
		else $error("nonzero solution with unsolved status");

	// the all-zero case reports a zero divisor
	a_inf_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_INFINITE) |-> (divisor == '0))
		else $error("nonzero divisor with infinite status");

endmodule

bind linear_diophantine_solver_unit ldsu_checker u_ldsu_checker (.*);
